@@ src/zrd_pkg.sv @@
// Package for the zero-run decompressor: phase codes, command constants
// and the result item type shared by the decoder, the queue and the top level.
// No dependencies.
package zrd_pkg;

  typedef enum logic [1:0] {
    PH_COMMAND = 2'd0,
    PH_LITERAL = 2'd1,
    PH_LENGTH  = 2'd2
  } phase_e;

  localparam logic [7:0]  LongRunCmd   = 8'hFF;
  localparam logic [7:0]  ZeroRunBias  = 8'd127;
  localparam logic [31:0] CapacityInit = 32'hFFFF_FFFF;
  localparam logic [1:0]  LastLenByte  = 2'd3;

  typedef struct packed {
    logic        run_present;
    logic [7:0]  run_byte;
    logic [31:0] run_count;
    logic        stream_done;
    logic        decode_error;
    logic [31:0] total_bytes;
  } result_t;

endpackage

@@ src/zrd_cfg_regs.sv @@
// Configuration register file of the zero-run decompressor: APB-style port
// holding the output capacity register. Depends on zrd_pkg.
module zrd_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] capacity_o
);
  import zrd_pkg::*;

  logic [31:0] capacity_q;
  logic        cap_sel;

  assign cap_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityInit;
    end else if (psel && penable && pwrite && cap_sel) begin
      capacity_q <= pwdata;
    end
  end

  assign prdata     = cap_sel ? capacity_q : 32'd0;
  assign capacity_o = capacity_q;

endmodule

@@ src/zrd_decode.sv @@
// Decode stage of the zero-run decompressor: stream state registers and the
// single-pass logic that turns one code byte into at most one result item.
// Depends on zrd_pkg.
module zrd_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     code_byte_i,
  input  logic           end_of_stream_i,
  input  logic [31:0]    capacity_i,
  output logic           emit_o,
  output zrd_pkg::result_t result_o
);
  import zrd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  lit_left_q, lit_left_d;
  logic [1:0]  len_seen_q, len_seen_d;
  logic [31:0] gather_q, gather_d;
  logic [31:0] produced_q, produced_d;
  logic        err_q, err_d;

  logic [31:0] gather_full;
  logic [31:0] run_len;
  logic [32:0] sum;
  logic        over;
  logic        run;
  logic [7:0]  rbyte;
  logic [31:0] rcount;
  logic        bad;

  always_comb begin
    unique case (len_seen_q)
      2'd0:    gather_full = gather_q | {24'd0, code_byte_i};
      2'd1:    gather_full = gather_q | {16'd0, code_byte_i, 8'd0};
      2'd2:    gather_full = gather_q | {8'd0, code_byte_i, 16'd0};
      default: gather_full = gather_q | {code_byte_i, 24'd0};
    endcase
  end

  always_comb begin
    unique case (phase_q)
      PH_LITERAL: run_len = 32'd1;
      PH_LENGTH:  run_len = gather_full;
      default: begin
        if (!code_byte_i[7]) begin
          run_len = {24'd0, code_byte_i} + 32'd1;
        end else begin
          run_len = {24'd0, code_byte_i - ZeroRunBias};
        end
      end
    endcase
  end

  assign sum  = {1'b0, produced_q} + {1'b0, run_len};
  assign over = sum > {1'b0, capacity_i};

  always_comb begin
    phase_d    = phase_q;
    lit_left_d = lit_left_q;
    len_seen_d = len_seen_q;
    gather_d   = gather_q;
    produced_d = produced_q;
    err_d      = err_q;
    run        = 1'b0;
    rbyte      = 8'd0;
    rcount     = 32'd0;
    bad        = 1'b0;

    if (!err_q) begin
      unique case (phase_q)
        PH_LITERAL: begin
          run        = 1'b1;
          rbyte      = code_byte_i;
          rcount     = 32'd1;
          produced_d = sum[31:0];
          lit_left_d = lit_left_q - 8'd1;
          if (lit_left_d == 8'd0) begin
            phase_d = PH_COMMAND;
          end
        end
        PH_LENGTH: begin
          if (len_seen_q == LastLenByte) begin
            phase_d    = PH_COMMAND;
            len_seen_d = 2'd0;
            gather_d   = 32'd0;
            if (over) begin
              err_d = 1'b1;
            end else if (gather_full != 32'd0) begin
              run        = 1'b1;
              rcount     = gather_full;
              produced_d = sum[31:0];
            end
          end else begin
            len_seen_d = len_seen_q + 2'd1;
            gather_d   = gather_full;
          end
        end
        default: begin
          if (produced_q < capacity_i) begin
            if (!code_byte_i[7]) begin
              if (over) begin
                err_d = 1'b1;
              end else begin
                lit_left_d = run_len[7:0];
                phase_d    = PH_LITERAL;
              end
            end else if (code_byte_i != LongRunCmd) begin
              if (over) begin
                err_d = 1'b1;
              end else begin
                run        = 1'b1;
                rcount     = run_len;
                produced_d = sum[31:0];
              end
            end else begin
              phase_d    = PH_LENGTH;
              len_seen_d = 2'd0;
              gather_d   = 32'd0;
            end
          end
        end
      endcase
    end

    bad = err_d || (phase_d != PH_COMMAND);

    result_o.run_present  = run;
    result_o.run_byte     = rbyte;
    result_o.run_count    = rcount;
    result_o.stream_done  = end_of_stream_i;
    result_o.decode_error = end_of_stream_i && bad;
    result_o.total_bytes  = (end_of_stream_i && !bad) ? produced_d : 32'd0;
    emit_o                = run || end_of_stream_i;

    if (end_of_stream_i) begin
      phase_d    = PH_COMMAND;
      lit_left_d = 8'd0;
      len_seen_d = 2'd0;
      gather_d   = 32'd0;
      produced_d = 32'd0;
      err_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_COMMAND;
      lit_left_q <= 8'd0;
      len_seen_q <= 2'd0;
      gather_q   <= 32'd0;
      produced_q <= 32'd0;
      err_q      <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      lit_left_q <= lit_left_d;
      len_seen_q <= len_seen_d;
      gather_q   <= gather_d;
      produced_q <= produced_d;
      err_q      <= err_d;
    end
  end

endmodule

@@ src/zrd_out_queue.sv @@
// Two-entry result queue of the zero-run decompressor: registers result items
// and absorbs receiver stalls so the input side keeps flowing. Depends on zrd_pkg.
module zrd_out_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  zrd_pkg::result_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           stall_i,
  output zrd_pkg::result_t data_o
);
  import zrd_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ src/zero_run_decompressor_core.sv @@
// Top level of the zero-run decompressor: configuration port, decode stage
// and result queue. Depends on zrd_pkg, zrd_cfg_regs, zrd_decode, zrd_out_queue.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one compressed byte per item
//   with end_of_stream_i marking the last byte. Output channel
//   (out_valid_o / out_stall_i) gives run descriptors and, on the last byte,
//   a done item with decode_error and total_bytes. A byte that yields no run
//   and is not last gives no output item.
//   Each result item is registered in the result queue when its byte is accepted.
//   Throughput: one byte per cycle while in_stall_o is low; decode is one add
//   and compare against the capacity register between the stream state and
//   the result queue. The two-entry result queue raises in_stall_o only when
//   both entries hold items the receiver has not yet taken.
//   Reset clears the stream state and the queue and sets the capacity to
//   all ones. After a done item the stream state returns to its reset value.
//   Write the capacity over the APB-style port at byte address 0 while idle.
module zero_run_decompressor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        run_present_o,
  output logic [7:0]  run_byte_o,
  output logic [31:0] run_count_o,
  output logic        stream_done_o,
  output logic        decode_error_o,
  output logic [31:0] total_bytes_o
);
  import zrd_pkg::*;

  logic [31:0] capacity;
  logic        accept;
  logic        emit;
  logic        full;
  result_t     dec_result;
  result_t     out_result;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  zrd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  zrd_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .code_byte_i     (code_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .capacity_i      (capacity),
    .emit_o          (emit),
    .result_o        (dec_result)
  );

  zrd_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && emit),
    .push_data_i (dec_result),
    .full_o      (full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_result)
  );

  assign run_present_o  = out_result.run_present;
  assign run_byte_o     = out_result.run_byte;
  assign run_count_o    = out_result.run_count;
  assign stream_done_o  = out_result.stream_done;
  assign decode_error_o = out_result.decode_error;
  assign total_bytes_o  = out_result.total_bytes;

endmodule

@@ tb/sv/zero_run_decompressor_core_chk.sv @@
`timescale 1ns / 1ps
// Checker for the zero-run decompressor: watches the config port and both item
// channels, predicts the run descriptors of each accepted code byte and compares
// them with the block's result items. Depends on zrd_pkg.
module zero_run_decompressor_core_chk #(
  parameter logic [2:0] CapAddr = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  code_byte_i,
  input  logic        end_of_stream_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        run_present_i,
  input  logic [7:0]  run_byte_i,
  input  logic [31:0] run_count_i,
  input  logic        stream_done_i,
  input  logic        decode_error_i,
  input  logic [31:0] total_bytes_i,
  output int          mismatch_count_o,
  output int          pending_o
);
  import zrd_pkg::*;

  localparam logic [7:0] LiteralLimit = 8'd128;

  logic [31:0] capacity;
  phase_e      phase;
  logic [7:0]  literal_left;
  logic [1:0]  len_seen;
  logic [31:0] len_gather;
  logic [31:0] produced;
  logic        err_flag;
  result_t     runs_due[$];
  int          mismatches;

  function automatic void clear_stream();
    phase        = PH_COMMAND;
    literal_left = '0;
    len_seen     = '0;
    len_gather   = '0;
    produced     = '0;
    err_flag     = 1'b0;
  endfunction

  function automatic logic fits_capacity(logic [31:0] n);
    if ({1'b0, produced} + {1'b0, n} > {1'b0, capacity}) begin
      err_flag = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic decode_code_byte(logic [7:0] b, logic last);
    result_t r;
    logic    run;
    logic    bad;
    r   = '0;
    run = 1'b0;
    if (err_flag) begin
    end else if (phase == PH_LITERAL) begin
      run          = 1'b1;
      r.run_byte   = b;
      r.run_count  = 32'd1;
      produced     = produced + 32'd1;
      literal_left = literal_left - 8'd1;
      if (literal_left == 8'd0) phase = PH_COMMAND;
    end else if (phase == PH_LENGTH) begin
      len_gather = len_gather | (32'(b) << (8 * len_seen));
      if (len_seen == LastLenByte) begin
        phase    = PH_COMMAND;
        len_seen = '0;
        if (fits_capacity(len_gather) && len_gather != 32'd0) begin
          run         = 1'b1;
          r.run_count = len_gather;
          produced    = produced + len_gather;
        end
        len_gather = '0;
      end else begin
        len_seen = len_seen + 2'd1;
      end
    end else if (produced < capacity) begin
      if (b < LiteralLimit) begin
        if (fits_capacity(32'(b) + 32'd1)) begin
          literal_left = b + 8'd1;
          phase        = PH_LITERAL;
        end
      end else if (b < LongRunCmd) begin
        if (fits_capacity(32'(b - ZeroRunBias))) begin
          run         = 1'b1;
          r.run_count = 32'(b - ZeroRunBias);
          produced    = produced + r.run_count;
        end
      end else begin
        phase      = PH_LENGTH;
        len_seen   = '0;
        len_gather = '0;
      end
    end
    if (!run && !last) return;
    r.run_present = run;
    if (last) begin
      bad            = err_flag || phase != PH_COMMAND;
      r.stream_done  = 1'b1;
      r.decode_error = bad;
      r.total_bytes  = bad ? 32'd0 : produced;
      clear_stream();
    end
    runs_due.push_back(r);
  endtask

  task automatic compare_run(result_t got);
    result_t want;
    if (runs_due.size() == 0) begin
      $error("result item with no run descriptor pending");
      mismatches++;
      return;
    end
    want = runs_due.pop_front();
    if (got.run_present !== want.run_present) begin
      $error("run_present: expected %0d, got %0d", want.run_present, got.run_present);
      mismatches++;
    end
    if (got.run_byte !== want.run_byte) begin
      $error("run_byte: expected %0h, got %0h", want.run_byte, got.run_byte);
      mismatches++;
    end
    if (got.run_count !== want.run_count) begin
      $error("run_count: expected %0d, got %0d", want.run_count, got.run_count);
      mismatches++;
    end
    if (got.stream_done !== want.stream_done) begin
      $error("stream_done: expected %0d, got %0d", want.stream_done, got.stream_done);
      mismatches++;
    end
    if (got.decode_error !== want.decode_error) begin
      $error("decode_error: expected %0d, got %0d", want.decode_error, got.decode_error);
      mismatches++;
    end
    if (got.total_bytes !== want.total_bytes) begin
      $error("total_bytes: expected %0d, got %0d", want.total_bytes, got.total_bytes);
      mismatches++;
    end
  endtask

  initial begin
    mismatches       = 0;
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      capacity = CapacityInit;
      clear_stream();
      runs_due.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == CapAddr) begin
        if (pwrite_i) begin
          capacity = pwdata_i;
        end else if (prdata_i !== capacity) begin
          $error("output_capacity: expected %0h, got %0h", capacity, prdata_i);
          mismatches++;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        compare_run('{run_present_i, run_byte_i, run_count_i,
                      stream_done_i, decode_error_i, total_bytes_i});
      end
      if (in_valid_i && !in_stall_i) decode_code_byte(code_byte_i, end_of_stream_i);
    end
    mismatch_count_o <= mismatches;
    pending_o        <= runs_due.size();
  end

endmodule

@@ tb/sv/zero_run_decompressor_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the zero-run decompressor testbench: clock, reset, config writes and
// code byte streams with random idling; the checker judges the result items.
// Depends on zrd_pkg, zero_run_decompressor_core, zero_run_decompressor_core_chk.
module zero_run_decompressor_core_tb;
  import zrd_pkg::*;

  localparam logic [2:0] CapAddr    = 3'd0;
  localparam int         CycleLimit = 400000;
  localparam int         HoldCycles = 80;
  localparam int         ModeItems  = 115;

  typedef enum logic [1:0] {
    IDLE_TX_LIGHT,
    IDLE_TX_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = CapAddr;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  code_byte_i     = '0;
  logic        end_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b1;
  logic        run_present_o;
  logic [7:0]  run_byte_o;
  logic [31:0] run_count_o;
  logic        stream_done_o;
  logic        decode_error_o;
  logic [31:0] total_bytes_o;

  int          mismatch_count;
  int          pending;
  int          cycles;
  int          mode_items;
  int          hold_left;
  logic        hold_used;
  idle_mode_e  idle_mode = IDLE_TX_LIGHT;
  logic [7:0]  stream_bytes[$];

  zero_run_decompressor_core dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .code_byte_i, .end_of_stream_i,
    .out_valid_o, .out_stall_i, .run_present_o, .run_byte_o, .run_count_o,
    .stream_done_o, .decode_error_o, .total_bytes_o
  );

  zero_run_decompressor_core_chk #(.CapAddr(CapAddr)) chk (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_i(prdata), .pready_i(pready),
    .in_valid_i, .in_stall_i(in_stall_o), .code_byte_i, .end_of_stream_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .run_present_i(run_present_o), .run_byte_i(run_byte_o), .run_count_i(run_count_o),
    .stream_done_i(stream_done_o), .decode_error_i(decode_error_o),
    .total_bytes_i(total_bytes_o),
    .mismatch_count_o(mismatch_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int tx_idle_pct();
    case (idle_mode)
      IDLE_TX_LIGHT: return 19;
      IDLE_TX_HEAVY: return 81;
      default:       return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (idle_mode)
      IDLE_TX_LIGHT: return 81;
      IDLE_TX_HEAVY: return 19;
      default:       return 0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left   <= 0;
      hold_used   <= 1'b0;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_used && idle_mode == IDLE_NONE && in_valid_i) begin
      hold_left   <= HoldCycles;
      hold_used   <= 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct());
    end
  end

  task automatic cfg_access(logic wr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CapAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [31:0] value);
    drain();
    cfg_access(1'b1, value);
    cfg_access(1'b0, '0);
  endtask

  task automatic send_code(logic [7:0] b, logic last);
    while ($urandom_range(99) < tx_idle_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    code_byte_i     <= b;
    end_of_stream_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mode_items++;
  endtask

  task automatic send_stream();
    foreach (stream_bytes[i]) send_code(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  task automatic load_stream(logic [7:0] codes[]);
    stream_bytes.delete();
    foreach (codes[i]) stream_bytes.push_back(codes[i]);
    send_stream();
  endtask

  function automatic logic [31:0] pick_capacity();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return $urandom_range(1, 16);
      2:       return $urandom_range(17, 600);
      3:       return CapacityInit;
      4:       return $urandom();
      default: return $urandom_range(1000, 100000);
    endcase
  endfunction

  task automatic build_stream();
    int          kind;
    int          len;
    logic [31:0] zeros;
    stream_bytes.delete();
    kind = $urandom_range(9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 10)) stream_bytes.push_back(8'($urandom()));
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          len = ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(7);
          stream_bytes.push_back(8'(len));
          repeat (len + 1) stream_bytes.push_back(8'($urandom()));
        end
        4, 5, 6: stream_bytes.push_back(8'($urandom_range(128, 254)));
        default: begin
          case ($urandom_range(3))
            0:       zeros = '0;
            1:       zeros = $urandom_range(1, 300);
            2:       zeros = $urandom();
            default: zeros = $urandom_range(300, 5000);
          endcase
          stream_bytes.push_back(LongRunCmd);
          for (int i = 0; i < 4; i++) stream_bytes.push_back(zeros[8*i +: 8]);
        end
      endcase
    end
    if (kind == 1 && stream_bytes.size() > 1) begin
      len = $urandom_range(1, stream_bytes.size() - 1);
      while (stream_bytes.size() > len) void'(stream_bytes.pop_back());
    end
  endtask

  task automatic random_streams();
    mode_items = 0;
    while (mode_items < ModeItems) begin
      if ($urandom_range(4) == 0) set_capacity(pick_capacity());
      build_stream();
      send_stream();
    end
  endtask

  initial begin
    cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_stream('{8'h00, 8'hFF, 8'h80, 8'hFE, LongRunCmd, 8'h00, 8'h00, 8'h00, 8'h00});
    load_stream('{8'h05, 8'h11});
    load_stream('{LongRunCmd, 8'h10});
    set_capacity(CapacityInit);
    load_stream('{LongRunCmd, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80});
    set_capacity(32'd3);
    load_stream('{8'h02, 8'h61, 8'h62, 8'h63, 8'h80});
    load_stream('{8'h85, 8'h00});
    set_capacity(32'd0);
    load_stream('{8'h80});

    set_capacity($urandom_range(20, 300));
    random_streams();

    idle_mode = IDLE_TX_HEAVY;
    set_capacity($urandom());
    random_streams();

    set_capacity(CapacityInit);
    idle_mode = IDLE_NONE;
    stream_bytes.delete();
    repeat (12) stream_bytes.push_back(8'($urandom_range(128, 254)));
    send_stream();
    random_streams();

    drain();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
